[design/vn_pkg.sv]
// vn_pkg: shared constants, word types and helpers for the vec3 normalize core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vn_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COMP_W      = 32;
    localparam int THR_W       = 17;
    localparam int SQ_W        = 2 * COMP_W;
    localparam int ROOT_W      = COMP_W;
    localparam int Q_W         = FRAC_BITS + 1;   // |c| <= mag, so q <= 2^FRAC_BITS
    localparam int SQRT_STEPS  = ROOT_W;
    localparam int DIV_STEPS   = Q_W;
    localparam int LAT         = 2 + SQRT_STEPS + DIV_STEPS;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = 1;

    localparam logic [REG_IDX_W-1:0] REG_ZERO_THRESHOLD = 1'b0;
    localparam logic [THR_W-1:0]     THR_RESET          = THR_W'(1);

    typedef struct packed {
        logic signed [COMP_W-1:0] in_x;
        logic signed [COMP_W-1:0] in_y;
        logic signed [COMP_W-1:0] in_z;
    } vn_in_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] out_x;
        logic signed [COMP_W-1:0] out_y;
        logic signed [COMP_W-1:0] out_z;
        logic                     degenerate;
    } vn_out_t;

    // two's complement magnitude; -2^31 maps to 2^31 in unsigned form
    function automatic logic [COMP_W-1:0] abs_of(input logic signed [COMP_W-1:0] c);
        logic [COMP_W-1:0] u;
        u = c;
        return c[COMP_W-1] ? (~u + COMP_W'(1)) : u;
    endfunction

endpackage
`default_nettype wire

[design/vn_sqr_lane.sv]
// vn_sqr_lane: one component lane, magnitude and registered square.
// Depends on vn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vn_sqr_lane
    import vn_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic signed [COMP_W-1:0] comp,
    output logic         [SQ_W-1:0]       sq_reg
);

    logic [COMP_W-1:0] mag;

    assign mag = abs_of(comp);

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg <= SQ_W'(mag) * SQ_W'(mag);
        end
    end

endmodule
`default_nettype wire

[design/vn_isqrt.sv]
// vn_isqrt: pipelined floor square root, one result bit per stage.
// Depends on vn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vn_isqrt
    import vn_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire logic [SQ_W-1:0]   rad,
    output logic      [ROOT_W-1:0] root
);

    localparam int REM_W = ROOT_W + 3;

    logic [REM_W-1:0]  rem_reg  [SQRT_STEPS];
    logic [ROOT_W-1:0] root_reg [SQRT_STEPS];
    logic [SQ_W-1:0]   rad_reg  [SQRT_STEPS];

    for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_step
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SQ_W-1:0]   rad_in;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;

        if (s == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
        end else begin : g_rest
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign rad_in  = rad_reg[s-1];
        end

        // bring down the next two radicand bits
        assign rem_sh = {rem_in[REM_W-3:0], rad_in[SQ_W-1 -: 2]};
        assign trial  = {1'b0, root_in, 2'b01};

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[s] <= {rad_in[SQ_W-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    rem_reg[s]  <= rem_sh - trial;
                    root_reg[s] <= {root_in[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg[s]  <= rem_sh;
                    root_reg[s] <= {root_in[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign root = root_reg[SQRT_STEPS-1];

endmodule
`default_nettype wire

[design/vn_div_lane.sv]
// vn_div_lane: one component lane, pipelined restoring divide (|c| << FRAC_BITS) / mag.
// Depends on vn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vn_div_lane
    import vn_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire logic [COMP_W-1:0] num,
    input  wire logic [ROOT_W-1:0] mag,
    output logic      [Q_W-1:0]    quo
);

    localparam int REM_W = ROOT_W + 1;

    logic [REM_W-1:0]  rem_reg [DIV_STEPS];
    logic [ROOT_W-1:0] mag_reg [DIV_STEPS];
    logic [Q_W-1:0]    quo_reg [DIV_STEPS];

    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] mag_in;
        logic [Q_W-1:0]    quo_in;
        logic              bit_in;
        logic [REM_W-1:0]  rem_sh;

        if (s == 0) begin : g_first
            // num >> 1 < mag whenever mag is nonzero, so high quotient bits are zero
            assign rem_in = REM_W'(num[COMP_W-1:1]);
            assign mag_in = mag;
            assign quo_in = '0;
            assign bit_in = num[0];
        end else begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign mag_in = mag_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign bit_in = 1'b0;
        end

        assign rem_sh = {rem_in[REM_W-2:0], bit_in};

        always_ff @(posedge aclk) begin
            if (en) begin
                mag_reg[s] <= mag_in;
                if (rem_sh >= REM_W'(mag_in)) begin
                    rem_reg[s] <= rem_sh - REM_W'(mag_in);
                    quo_reg[s] <= {quo_in[Q_W-2:0], 1'b1};
                end else begin
                    rem_reg[s] <= rem_sh;
                    quo_reg[s] <= {quo_in[Q_W-2:0], 1'b0};
                end
            end
        end
    end

    assign quo = quo_reg[DIV_STEPS-1];

endmodule
`default_nettype wire

[design/vec3_normalize_core.sv]
// vec3_normalize_core: top level, three-lane vector normalizer with APB threshold register.
// Depends on vn_pkg, vn_sqr_lane, vn_isqrt, vn_div_lane.
//
// Usage:
//   Input words (s_valid/s_ready, s_data) carry x, y, z in signed Q16.16.
//   Output words (m_valid/m_ready, m_data) carry the unit vector in Q16.16,
//   or the input unchanged with degenerate set when the magnitude is zero
//   or below zero_threshold (APB address 0, 17 bits, reset 1).
//   Throughput: one word per cycle while the pipe does not hold. There are
//   52 register stages, the first loaded at the accepting edge:
//   1 square, 1 sum, 32 square-root stages (one root bit each),
//   17 divide stages (one quotient bit each per lane), 1 merge/output.
//   Three lanes square and divide x, y, z side by side; the merge stage
//   applies sign and the threshold select.
//   A skid register behind the output register takes one more word while
//   the receiver stalls; s_ready drops only when that skid is full, and the
//   whole pipe then holds. Reset clears all valid state and the threshold
//   returns to 1. Write the threshold only while the core is empty.
`timescale 1ns / 1ps
`default_nettype none
module vec3_normalize_core
    import vn_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire vn_in_t                s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output vn_out_t                    m_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int DIV_IN = 2 + SQRT_STEPS - 1;

    logic              adv;
    logic [THR_W-1:0]  thr_reg;
    logic [REG_IDX_W-1:0] reg_idx;

    vn_in_t            pl_reg  [LAT];
    logic              vld_reg [LAT];
    logic              deg_reg [DIV_STEPS];

    logic [SQ_W-1:0]   sq_x, sq_y, sq_z;
    logic [SQ_W-1:0]   sum_reg;
    logic [ROOT_W-1:0] root;
    logic [Q_W-1:0]    q_x, q_y, q_z;

    vn_out_t           p_word;
    logic              p_vld;
    vn_out_t           out_reg, skid_reg;
    logic              out_vld_reg, skid_vld_reg;

    // ---------------- config port ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1 -: REG_IDX_W];
    assign prdata  = (reg_idx == REG_ZERO_THRESHOLD) ? APB_DATA_W'(thr_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (psel && penable && pwrite && reg_idx == REG_ZERO_THRESHOLD) begin
            thr_reg <= pwdata[THR_W-1:0];
        end
    end

    // ---------------- pipeline ----------------
    assign adv     = !skid_vld_reg;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (adv) begin
            pl_reg[0] <= s_data;
            for (int i = 1; i < LAT; i++) begin
                pl_reg[i] <= pl_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < LAT; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    vn_sqr_lane u_sq_x (.aclk(aclk), .en(adv), .comp(s_data.in_x), .sq_reg(sq_x));
    vn_sqr_lane u_sq_y (.aclk(aclk), .en(adv), .comp(s_data.in_y), .sq_reg(sq_y));
    vn_sqr_lane u_sq_z (.aclk(aclk), .en(adv), .comp(s_data.in_z), .sq_reg(sq_z));

    // three squares of at most 2^62 each fit in 64 bits
    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_reg <= sq_x + sq_y + sq_z;
        end
    end

    vn_isqrt u_isqrt (.aclk(aclk), .en(adv), .rad(sum_reg), .root(root));

    vn_div_lane u_div_x (.aclk(aclk), .en(adv), .num(abs_of(pl_reg[DIV_IN].in_x)),
                         .mag(root), .quo(q_x));
    vn_div_lane u_div_y (.aclk(aclk), .en(adv), .num(abs_of(pl_reg[DIV_IN].in_y)),
                         .mag(root), .quo(q_y));
    vn_div_lane u_div_z (.aclk(aclk), .en(adv), .num(abs_of(pl_reg[DIV_IN].in_z)),
                         .mag(root), .quo(q_z));

    always_ff @(posedge aclk) begin
        if (adv) begin
            deg_reg[0] <= (root == '0) || (root < ROOT_W'(thr_reg));
            for (int i = 1; i < DIV_STEPS; i++) begin
                deg_reg[i] <= deg_reg[i-1];
            end
        end
    end

    // ---------------- merge ----------------
    function automatic logic signed [COMP_W-1:0] apply_sign(input logic [Q_W-1:0] q,
                                                            input logic neg);
        logic [COMP_W-1:0] w;
        w = COMP_W'(q);
        return neg ? (COMP_W'(0) - w) : w;
    endfunction

    always_comb begin
        vn_in_t src;
        src   = pl_reg[LAT-1];
        p_vld = vld_reg[LAT-1];
        if (deg_reg[DIV_STEPS-1]) begin
            p_word.out_x = src.in_x;
            p_word.out_y = src.in_y;
            p_word.out_z = src.in_z;
        end else begin
            p_word.out_x = apply_sign(q_x, src.in_x[COMP_W-1]);
            p_word.out_y = apply_sign(q_y, src.in_y[COMP_W-1]);
            p_word.out_z = apply_sign(q_z, src.in_z[COMP_W-1]);
        end
        p_word.degenerate = deg_reg[DIV_STEPS-1];
    end

    // ---------------- output register + skid ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            priority if (out_vld_reg && m_ready) begin
                if (skid_vld_reg) begin
                    out_reg      <= skid_reg;
                    skid_vld_reg <= 1'b0;
                end else begin
                    out_vld_reg <= p_vld;
                    out_reg     <= p_word;
                end
            end else if (!out_vld_reg) begin
                out_vld_reg <= p_vld;
                out_reg     <= p_word;
            end else begin
                // output held: park the next word in the skid
                if (p_vld && adv) begin
                    skid_reg     <= p_word;
                    skid_vld_reg <= 1'b1;
                end
            end
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid holds a word while output register is empty");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_vld_reg) |-> $past(out_vld_reg && !m_ready))
        else $error("skid filled without a stalled output");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !out_vld_reg && !skid_vld_reg)
        else $error("valid state survived reset");

    a_quo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (p_vld && !deg_reg[DIV_STEPS-1]) |->
        (q_x <= Q_W'(1) << FRAC_BITS) && (q_y <= Q_W'(1) << FRAC_BITS)
        && (q_z <= Q_W'(1) << FRAC_BITS))
        else $error("quotient exceeds unit");
`endif

endmodule
`default_nettype wire

[test/vec3_normalize_core_tb.sv]
// vec3_normalize_core_tb: self-checking bench for the vec3 normalize core.
// Depends on vn_pkg and vec3_normalize_core; predicts each result in a scoreboard class.
`timescale 1ns / 1ps
module vec3_normalize_core_tb;
    import vn_pkg::*;

    localparam int WD_LIMIT = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    vn_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    vn_out_t m_data;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    always #5 aclk = ~aclk;

    vec3_normalize_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    class norm_scoreboard;
        logic [THR_W-1:0] thr;
        vn_out_t pending[$];
        int errors;

        function new();
            thr = THR_RESET;
            errors = 0;
        endfunction

        function logic [63:0] root_floor(logic [63:0] n);
            logic [63:0] rem, root, b;
            rem = n; root = 0; b = 64'd1 << 62;
            while (b > rem) b = b >> 2;
            while (b != 0) begin
                if (rem >= root + b) begin
                    rem = rem - (root + b);
                    root = (root >> 1) + b;
                end else begin
                    root = root >> 1;
                end
                b = b >> 2;
            end
            return root;
        endfunction

        function logic [COMP_W-1:0] unit_comp(logic signed [COMP_W-1:0] c, logic [63:0] mag);
            logic [63:0] a, q;
            a = c[COMP_W-1] ? (64'h1_0000_0000 - {32'd0, c}) : {32'd0, c};
            q = (a << FRAC_BITS) / mag;
            if (c[COMP_W-1]) q = -q;
            return q[COMP_W-1:0];
        endfunction

        function void note_input(vn_in_t v);
            logic [63:0] ax, ay, az, mag;
            vn_out_t r;
            ax = v.in_x[31] ? (64'h1_0000_0000 - {32'd0, v.in_x}) : {32'd0, v.in_x};
            ay = v.in_y[31] ? (64'h1_0000_0000 - {32'd0, v.in_y}) : {32'd0, v.in_y};
            az = v.in_z[31] ? (64'h1_0000_0000 - {32'd0, v.in_z}) : {32'd0, v.in_z};
            mag = root_floor(ax * ax + ay * ay + az * az);
            if (mag == 0 || mag < {47'd0, thr}) begin
                r.out_x = v.in_x; r.out_y = v.in_y; r.out_z = v.in_z;
                r.degenerate = 1'b1;
            end else begin
                r.out_x = unit_comp(v.in_x, mag);
                r.out_y = unit_comp(v.in_y, mag);
                r.out_z = unit_comp(v.in_z, mag);
                r.degenerate = 1'b0;
            end
            pending.push_back(r);
        endfunction

        function void check_result(vn_out_t got);
            vn_out_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.out_x !== e.out_x)
                $display("%0t: out_x exp %h got %h", $time, e.out_x, got.out_x);
            if (got.out_y !== e.out_y)
                $display("%0t: out_y exp %h got %h", $time, e.out_y, got.out_y);
            if (got.out_z !== e.out_z)
                $display("%0t: out_z exp %h got %h", $time, e.out_z, got.out_z);
            if (got.degenerate !== e.degenerate)
                $display("%0t: degenerate exp %b got %b", $time, e.degenerate, got.degenerate);
            if (got !== e) errors++;
        endfunction
    endclass

    norm_scoreboard sb = new();
    int idle_cycles = 0;
    bit hold_rx = 1'b0;
    bit timed_out = 1'b0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge aclk) begin
        if (idle_cycles >= WD_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int gap_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (hold_rx) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_rx = 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                n = gap_len() + 1;
                repeat (n) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_word(vn_in_t v, bit gaps);
        int n;
        s_valid <= 1'b1;
        s_data <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (gaps && $urandom_range(0, 2) == 0) begin
            n = gap_len();
            if (n > 0) begin
                s_valid <= 1'b0;
                repeat (n) @(posedge aclk);
            end
        end
    endtask

    task automatic end_burst();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LAT + 10) @(posedge aclk);
    endtask

    task automatic write_thr(logic [THR_W-1:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(4 * REG_ZERO_THRESHOLD);
        pwdata <= {15'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.thr = val;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_comp(int scale);
        case (scale)
            0: return $urandom();
            1: return $signed($urandom_range(0, 255)) - 128;
            2: return $signed($urandom_range(0, 1 << 18)) - (1 << 17);
            default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
        endcase
    endfunction

    function automatic vn_in_t rand_vec();
        vn_in_t v;
        int s;
        s = $urandom_range(0, 9);
        s = (s < 5) ? 0 : (s < 7) ? 1 : (s < 9) ? 2 : 3;
        v.in_x = rand_comp(s); v.in_y = rand_comp(s); v.in_z = rand_comp(s);
        return v;
    endfunction

    function automatic vn_in_t mk(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        vn_in_t v;
        v.in_x = x; v.in_y = y; v.in_z = z;
        return v;
    endfunction

    initial begin
        logic [THR_W-1:0] thr_set[5];
        thr_set = '{17'd0, 17'd65536, 17'd131071, 17'd300, 17'd1};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero, extremes, tiny magnitudes, most negative
        send_word(mk(0, 0, 0), 0);
        send_word(mk(1, 0, 0), 0);
        send_word(mk(32'hffff_ffff, 0, 0), 0);
        send_word(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 0);
        send_word(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), 0);
        send_word(mk(32'h8000_0000, 0, 0), 0);
        send_word(mk(0, 32'h7fff_ffff, 0), 0);
        send_word(mk(0, 0, 32'h0001_0000), 0);
        send_word(mk(32'hffff_0000, 32'h0001_0000, 32'hffff_0000), 0);
        send_word(mk(3, 4, 0), 0);
        end_burst();
        drain();
        write_thr(17'd0);
        send_word(mk(0, 0, 0), 0);
        send_word(mk(1, 1, 1), 0);
        end_burst();
        drain();
        write_thr(17'd131071);
        send_word(mk(32'h0001_ffff, 0, 0), 0);
        send_word(mk(32'h0002_0000, 0, 0), 0);
        send_word(mk(0, 32'hfffe_0001, 0), 0);
        end_burst();
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            write_thr(thr_set[ph]);
            if (ph == 2) hold_rx = 1'b1;
            for (int i = 0; i < 260; i++) send_word(rand_vec(), ph != 2);
            end_burst();
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
